// ===== rtl/pli_pkg.sv =====
// Shared types, field widths and codes for the positional list engine.
`default_nettype none

package pli_pkg;

    // Fixed field widths of the request and response transactions
    localparam int OP_W   = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic start_walk;
        logic walk_rd;
        logic walk_wr;
        logic ins_wr;
        logic peek_rd;
        logic finish;
    } pli_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic            ok;
        logic [OP_W-1:0] op;
        logic            walk_skip;
        logic            walk_last;
        logic            out_free;
    } pli_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pli_req_if.sv =====
// Request channel: operation, position and value with valid/ready.
`default_nettype none

interface pli_req_if;
    import pli_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink   (input valid, input operation, input position, input item_value,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pli_rsp_if.sv =====
// Response channel: read value, status and list length with valid/ready.
`default_nettype none

interface pli_rsp_if;
    import pli_pkg::*;

    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  list_length;

    modport source (output valid, output read_value, output status, output list_length,
                    input ready);
    modport sink   (input valid, input read_value, input status, input list_length,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pli_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pli_ctrl.sv =====
// Controller state machine: sequences checks, entry moves and the result.
`default_nettype none

module pli_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output pli_pkg::pli_cmd_t   cmd,
    input  pli_pkg::pli_stat_t  stat
);
    import pli_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EVAL    = 7'b0000010,
        S_SH_RD   = 7'b0000100,
        S_SH_WR   = 7'b0001000,
        S_INS_WR  = 7'b0010000,
        S_PEEK_RD = 7'b0100000,
        S_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!stat.ok)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    unique case (stat.op)
                        OP_INSERT:
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = stat.walk_skip ? S_INS_WR : S_SH_RD;
                        end
                        OP_REMOVE:
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = stat.walk_skip ? S_FINISH : S_SH_RD;
                        end
                        OP_PEEK:
                        begin
                            state_next = S_PEEK_RD;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SH_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.walk_wr = 1'b1;
                if (!stat.walk_last)
                begin
                    state_next = S_SH_RD;
                end
                else if (stat.op == OP_INSERT)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = S_FINISH;
            end
            S_PEEK_RD:
            begin
                cmd.peek_rd = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after a request transaction");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_wr |-> $past(cmd.walk_rd))
        else $error("entry move write without a preceding read");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result loaded while the output register was busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/pli_datapath.sv =====
// Datapath: request registers, length counter, walk pointer, entry RAM, result register.
`default_nettype none

module pli_datapath #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pli_pkg::OP_W-1:0]    operation,
    input  logic [pli_pkg::POS_W-1:0]   position,
    input  logic [pli_pkg::VAL_W-1:0]   item_value,
    input  pli_pkg::pli_cmd_t           cmd,
    output pli_pkg::pli_stat_t          stat,
    pli_rsp_if.source                   response
);
    import pli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = (CW > POS_W) ? CW : POS_W;
    localparam int WW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

    // Request registers
    logic [OP_W-1:0]       op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    // Control registers
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // Result registers
    logic [VAL_W-1:0]  rv_reg;
    status_t           st_reg;
    logic [LEN_W-1:0]  len_reg;

    logic [LW-1:0]         pos_x;
    logic [LW-1:0]         cnt_x;
    logic [LW-1:0]         cnt_next_x;
    logic [AW-1:0]         pos_a;
    logic [AW-1:0]         cnt_a;
    logic [CW-1:0]         cnt_m1;
    logic [AW-1:0]         last_a;
    logic [AW-1:0]         src_a;
    logic                  is_ins;
    logic                  is_rem;
    logic                  is_peek;
    status_t               status_c;
    logic                  ok;
    logic [WW-1:0]         val_wide;
    logic [WW-1:0]         rd_wide;
    logic [VAL_W-1:0]      rv_c;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    assign pos_x   = LW'(pos_reg);
    assign cnt_x   = LW'(count_reg);
    assign pos_a   = pos_x[AW-1:0];
    assign cnt_a   = cnt_x[AW-1:0];
    assign cnt_m1  = count_reg - CW'(1);
    assign last_a  = cnt_m1[AW-1:0];
    assign is_ins  = (op_reg == OP_INSERT);
    assign is_rem  = (op_reg == OP_REMOVE);
    assign is_peek = (op_reg == OP_PEEK);

    // Bounds and fill checks
    always_comb
    begin
        unique case (op_reg)
            OP_INSERT:
            begin
                if (pos_x > cnt_x)
                begin
                    status_c = ST_RANGE;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    status_c = ST_OK;
                end
            end
            OP_REMOVE, OP_PEEK:
            begin
                if (count_reg == '0)
                begin
                    status_c = ST_EMPTY;
                end
                else if (pos_x >= cnt_x)
                begin
                    status_c = ST_RANGE;
                end
                else
                begin
                    status_c = ST_OK;
                end
            end
            default:
            begin
                status_c = ST_RANGE;
            end
        endcase
    end

    assign ok = (status_c == ST_OK);

    // Walk source: one entry toward the position for insert, away for remove
    assign src_a = is_ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));

    assign stat.ok        = ok;
    assign stat.op        = op_reg;
    assign stat.walk_skip = is_ins ? (pos_x == cnt_x) : ((pos_x + LW'(1)) == cnt_x);
    assign stat.walk_last = is_ins ? (src_a == pos_a) : (src_a == last_a);
    assign stat.out_free  = !out_valid_reg || response.ready;

    // Walk pointer holds the destination of the next entry move
    always_comb
    begin
        priority if (cmd.start_walk)
        begin
            ptr_next = is_ins ? cnt_a : pos_a;
        end
        else if (cmd.walk_wr)
        begin
            ptr_next = src_a;
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    // Length update when the result is produced
    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish && ok && is_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.finish && ok && is_rem)
        begin
            count_next = cnt_m1;
        end
    end

    // RAM port steering
    assign val_wide    = WW'(item_value);
    assign ram_wr_en   = cmd.walk_wr || cmd.ins_wr;
    assign ram_wr_addr = cmd.ins_wr ? pos_a : ptr_reg;
    assign ram_wr_data = cmd.ins_wr ? val_reg : ram_rd_data;
    assign ram_rd_en   = cmd.walk_rd || cmd.peek_rd;
    assign ram_rd_addr = cmd.walk_rd ? src_a : pos_a;

    pli_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result payload
    assign rd_wide    = WW'(ram_rd_data);
    assign rv_c       = (ok && is_peek) ? rd_wide[VAL_W-1:0] : '0;
    assign cnt_next_x = LW'(count_next);

    assign out_valid_next = cmd.finish ? 1'b1 : (response.ready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            val_reg <= val_wide[DATA_WIDTH-1:0];
        end
    end

    // Result capture
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rv_reg  <= rv_c;
            st_reg  <= status_c;
            len_reg <= cnt_next_x[LEN_W-1:0];
        end
    end

    assign response.valid       = out_valid_reg;
    assign response.read_value  = rv_reg;
    assign response.status      = st_reg;
    assign response.list_length = len_reg;

`ifndef NO_ASSERTIONS
    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && ok && is_ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("successful insert did not grow the list by one");

    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && ok && is_rem |=> count_reg == $past(count_reg) - CW'(1))
        else $error("successful remove did not shrink the list by one");

    a_ins_wr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_wr |-> is_ins && ok)
        else $error("new entry written for a request that failed its checks");
`endif

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine_top.sv =====
// Top level of the positional list engine: controller, datapath and channel wiring.
//
// Ordered list of up to CAPACITY values of DATA_WIDTH bits, accessed by position.
// Each request transaction (insert, remove, peek) produces exactly one response
// transaction with the read value, a status code and the new length. One request
// is worked on at a time; a finished response waits in an output register while
// the next request is taken. Entries live in a single RAM with one write and one
// registered read port, and an entry move is a read followed by a write. An insert
// shifts the entries from its position onward up by one place, then writes the new
// value; a remove shifts the later entries down by one; a peek reads one entry; a
// rejected request goes straight to its response. No clearing pass follows reset.
`default_nettype none

module positional_list_engine_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    pli_req_if.sink    request,
    pli_rsp_if.source  response
);
    import pli_pkg::*;

    pli_cmd_t  cmd;
    pli_stat_t stat;
    logic      in_ready;

    assign request.ready = in_ready;

    pli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pli_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (request.operation),
        .position   (request.position),
        .item_value (request.item_value),
        .cmd        (cmd),
        .stat       (stat),
        .response   (response)
    );

endmodule

`default_nettype wire
